// ----- rtl/core/rard_pkg.sv -----
// package for the rotate-add random draw block: constants, control word, microcode rom
package rard_pkg;

    localparam logic [31:0] HI_RESET    = 32'h6000_9755;
    localparam logic [31:0] LO_RESET    = 32'hdead_beef;
    localparam logic [31:0] SEED_XOR    = 32'hbead_29ba;
    localparam logic [31:0] LOW31_MASK  = 32'h7fff_ffff;
    localparam int          FRAC_BITS   = 16;
    localparam int          DIV_STEPS   = 32;
    localparam int          WARMUP_DEF  = 32;

    // operation codes carried in tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // microcode addresses
    localparam int          PC_W    = 4;
    localparam logic [3:0]  ST_WAIT = 4'd0;
    localparam logic [3:0]  ST_DISP = 4'd1;
    localparam logic [3:0]  ST_ADV  = 4'd2;
    localparam logic [3:0]  ST_INIT = 4'd3;
    localparam logic [3:0]  ST_DIV  = 4'd4;
    localparam logic [3:0]  ST_REM  = 4'd5;
    localparam logic [3:0]  ST_LIM  = 4'd6;
    localparam logic [3:0]  ST_SEED = 4'd7;
    localparam logic [3:0]  ST_WARM = 4'd8;
    localparam logic [3:0]  ST_ZERO = 4'd9;

    // jump conditions
    localparam logic [2:0] C_NEVER      = 3'd0;
    localparam logic [2:0] C_ALWAYS     = 3'd1;
    localparam logic [2:0] C_NOT_ACC    = 3'd2;
    localparam logic [2:0] C_RESEED     = 3'd3;
    localparam logic [2:0] C_LIM_NOTPOS = 3'd4;
    localparam logic [2:0] C_CNT_MORE   = 3'd5;
    localparam logic [2:0] C_NO_WARM    = 3'd6;

    // result select
    localparam logic [1:0] RS_ZERO = 2'd0;
    localparam logic [1:0] RS_REM  = 2'd1;
    localparam logic [1:0] RS_LIM  = 2'd2;

    typedef struct packed {
        logic             adv;
        logic             ld_seed;
        logic             div_init;
        logic             div_step;
        logic             cnt_ld_div;
        logic             cnt_ld_warm;
        logic             cnt_dec;
        logic             emit;
        logic [1:0]       rsel;
        logic [2:0]       cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        begin
            w        = '0;
            w.cond   = C_NEVER;
            w.target = ST_WAIT;
            w.rsel   = RS_ZERO;
            case (pc)
                ST_WAIT: begin
                    w.cond   = C_NOT_ACC;
                    w.target = ST_WAIT;
                end
                ST_DISP: begin
                    w.cond   = C_RESEED;
                    w.target = ST_SEED;
                end
                ST_ADV: begin
                    w.adv = 1'b1;
                end
                ST_INIT: begin
                    w.div_init   = 1'b1;
                    w.cnt_ld_div = 1'b1;
                    w.cond       = C_LIM_NOTPOS;
                    w.target     = ST_LIM;
                end
                ST_DIV: begin
                    w.div_step = 1'b1;
                    w.cnt_dec  = 1'b1;
                    w.cond     = C_CNT_MORE;
                    w.target   = ST_DIV;
                end
                ST_REM: begin
                    w.emit   = 1'b1;
                    w.rsel   = RS_REM;
                    w.cond   = C_ALWAYS;
                    w.target = ST_WAIT;
                end
                ST_LIM: begin
                    w.emit   = 1'b1;
                    w.rsel   = RS_LIM;
                    w.cond   = C_ALWAYS;
                    w.target = ST_WAIT;
                end
                ST_SEED: begin
                    w.ld_seed     = 1'b1;
                    w.cnt_ld_warm = 1'b1;
                    w.cond        = C_NO_WARM;
                    w.target      = ST_ZERO;
                end
                ST_WARM: begin
                    w.adv     = 1'b1;
                    w.cnt_dec = 1'b1;
                    w.cond    = C_CNT_MORE;
                    w.target  = ST_WARM;
                end
                ST_ZERO: begin
                    w.emit   = 1'b1;
                    w.rsel   = RS_ZERO;
                    w.cond   = C_ALWAYS;
                    w.target = ST_WAIT;
                end
                default: begin
                    w.cond   = C_ALWAYS;
                    w.target = ST_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ----- rtl/core/rotate_add_random_draw.sv -----
// rotate-add random generator with signed 16.16 limit, microcoded sequencer and datapath
//
// usage
//   slave channel: one transaction per request. tuser selects the operation
//   (draw or reseed), tdata carries the signed 16.16 limit or the seed.
//   master channel: one transaction per request with the 16.16 result; a
//   reseed answers zero.
// steps per request
//   draw, positive limit : the 32 steps of the restoring remainder
//   reseed               : one rotate-add per warm-up step
//   the result appears in the output register on the cycle after its step
// the sequencer walks a small rom; one control word per step, a step counter
// and conditional jumps steer the seed registers and the remainder unit.
// s_axis_tready is high only out of reset while the sequencer waits at its
// first step, so one request is in flight at a time; a finished result may
// wait in the output register while the next request is taken.
// reset loads the seed words with their fixed start values and empties the
// output register. a stalled receiver holds the result; the sequencer then
// waits at its result step until the register frees up.
module rotate_add_random_draw #(
    parameter int WARMUP_STEPS = rard_pkg::WARMUP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic signed [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic               s_axis_tuser,   // [0] operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic signed [31:0] m_axis_tdata    // [31:0] random_value
);
    import rard_pkg::*;

    // counter covers both the remainder loop and the warm-up loop
    localparam int CNT_MAX = (WARMUP_STEPS > DIV_STEPS) ? WARMUP_STEPS : DIV_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_op;
    logic [31:0]      r_val;
    logic [31:0]      r_hi;
    logic [31:0]      r_lo;
    logic [31:0]      r_rem;
    logic [31:0]      r_quo;
    logic [31:0]      r_out;
    logic             r_out_valid;

    t_ctrl       w;
    logic        in_acc;
    logic        out_blocked;
    logic        take;
    logic [31:0] adv_hi;
    logic [31:0] trial;
    logic        trial_ge;
    logic [31:0] lim_res;
    logic [31:0] res_sel;
    logic [31:0] seed_m;

    assign w             = rom_word(r_pc);
    assign s_axis_tready = i_rst_n && (r_pc == ST_WAIT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_blocked   = r_out_valid && !m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // jump condition
    always_comb begin
        case (w.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NOT_ACC:    take = !in_acc;
            C_RESEED:     take = (r_op == OP_RESEED);
            C_LIM_NOTPOS: take = r_val[31] || (r_val == 32'd0);
            C_CNT_MORE:   take = (r_cnt != CNT_W'(1));
            C_NO_WARM:    take = (WARMUP_STEPS == 0);
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        if (w.emit && out_blocked) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    // rotate by the fraction width, then add the low word
    assign adv_hi = {r_hi[FRAC_BITS-1:0], r_hi[31:FRAC_BITS]} + r_lo;

    // restoring remainder: remainder stays below the positive limit
    assign trial    = {r_rem[30:0], r_quo[31]};
    assign trial_ge = (trial >= r_val);

    // limit <= 0: values in [limit,0) are offset by the limit
    always_comb begin
        if (r_val == 32'd0) begin
            lim_res = 32'd0;
        end else if (r_hi[31] && (r_hi >= r_val)) begin
            lim_res = r_hi - r_val;
        end else begin
            lim_res = r_hi;
        end
    end

    always_comb begin
        case (w.rsel)
            RS_ZERO: res_sel = 32'd0;
            RS_REM:  res_sel = r_rem;
            RS_LIM:  res_sel = lim_res;
            default: res_sel = 32'd0;
        endcase
    end

    assign seed_m = r_val & LOW31_MASK;

    // sequencer and seed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_WAIT;
            r_cnt       <= '0;
            r_hi        <= HI_RESET;
            r_lo        <= LO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w.cnt_ld_div) begin
                r_cnt <= CNT_W'(DIV_STEPS);
            end else if (w.cnt_ld_warm) begin
                r_cnt <= CNT_W'(WARMUP_STEPS);
            end else if (w.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w.adv) begin
                r_hi <= adv_hi;
                r_lo <= r_lo + adv_hi;
            end else if (w.ld_seed) begin
                if (r_val == 32'd0) begin
                    r_hi <= HI_RESET;
                    r_lo <= LO_RESET;
                end else begin
                    r_hi <= seed_m ^ SEED_XOR;
                    r_lo <= seed_m;
                end
            end
            if (w.emit && !out_blocked) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= s_axis_tuser;
            r_val <= s_axis_tdata;
        end
        if (w.div_init) begin
            r_rem <= 32'd0;
            r_quo <= r_hi;
        end else if (w.div_step) begin
            r_rem <= trial_ge ? (trial - r_val) : trial;
            r_quo <= {r_quo[30:0], 1'b0};
        end
        if (w.emit && !out_blocked) begin
            r_out <= res_sel;
        end
    end

    // a reseed request goes from dispatch straight to the seed load
    a_reseed_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser == OP_RESEED)) |=> ##1 (r_pc == ST_SEED))
        else $error("reseed request did not reach seed load");

    // remainder stays below the limit throughout the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == ST_DIV) || (r_pc == ST_REM)) |-> (r_rem < r_val))
        else $error("remainder not below limit");

    // a result step waits while the output register is held
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w.emit && out_blocked) |=> ($stable(r_pc) && $stable(r_out)))
        else $error("result step moved while output stalled");

    // an accepted request goes on to dispatch; requests are only taken at the wait step
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_pc == ST_DISP))
        else $error("accepted request did not go to dispatch");

endmodule
